@@ hdl/kcv_pkg.sv @@
// Shared types, codes and micro-program for the constant-velocity Kalman filter.
package kcv_pkg;

  localparam int AW  = 5;
  localparam int PCW = 6;
  localparam int RF_DEPTH = 32;

  typedef enum logic [3:0] {
    OP_LD, OP_ADD, OP_SUB, OP_SHR1, OP_SHR2, OP_MUL, OP_DIV, OP_OUTP, OP_OUTV, OP_OUTC
  } op_e;

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EXEC, S_WAIT, S_EMIT} state_e;

  localparam logic [1:0] CFG_DT = 2'd0;
  localparam logic [1:0] CFG_SG = 2'd1;
  localparam logic [1:0] CFG_R  = 2'd2;

  localparam logic [15:0] DT_RESET = 16'd6554;
  localparam logic [23:0] SG_RESET = 24'd13107;
  localparam logic [31:0] R_RESET  = 32'd65536;

  localparam logic [AW-1:0] R_POS = 5'd0,  R_VEL = 5'd1,  R_CPP = 5'd2,  R_CPV = 5'd3;
  localparam logic [AW-1:0] R_CVV = 5'd4,  R_NPP = 5'd5,  R_NPV = 5'd6,  R_NVV = 5'd7;
  localparam logic [AW-1:0] R_DT  = 5'd8,  R_SG  = 5'd9,  R_R   = 5'd10, R_Z   = 5'd11;
  localparam logic [AW-1:0] R_S2  = 5'd12, R_D2  = 5'd13, R_D3  = 5'd14, R_D4  = 5'd15;
  localparam logic [AW-1:0] R_T   = 5'd16, R_A   = 5'd17, R_B   = 5'd18, R_Y   = 5'd19;
  localparam logic [AW-1:0] R_S   = 5'd20, R_K0  = 5'd21, R_K1  = 5'd22, R_G   = 5'd23;
  localparam logic [AW-1:0] R_M00 = 5'd24, R_M01 = 5'd25, R_M10 = 5'd26, R_M11 = 5'd27;
  localparam logic [AW-1:0] R_KR0 = 5'd28, R_KR1 = 5'd29, R_U   = 5'd30, R_ONE = 5'd31;

  localparam logic [AW-1:0] SRC_ZERO = 5'd0, SRC_ONE = 5'd1, SRC_TEN = 5'd2;
  localparam logic [AW-1:0] SRC_DT = 5'd3, SRC_SG = 5'd4, SRC_R = 5'd5, SRC_Z = 5'd6;

  localparam logic [PCW-1:0] PC_INIT  = 6'd0;
  localparam logic [PCW-1:0] PC_NOISE = 6'd5;
  localparam logic [PCW-1:0] PC_STEP  = 6'd16;

  typedef struct packed {
    op_e           op;
    logic [AW-1:0] dst;
    logic [AW-1:0] sa;
    logic [AW-1:0] sb;
    logic          last;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic exec;
    logic wb;
    logic accept;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic out_free;
    logic cfg_noise;
  } sts_t;

  function automatic uop_t mk(input op_e op, input logic [AW-1:0] d, input logic [AW-1:0] a,
                              input logic [AW-1:0] b, input logic l);
    uop_t u;
    u.op = op; u.dst = d; u.sa = a; u.sb = b; u.last = l;
    return u;
  endfunction

  function automatic uop_t ucode(input logic [PCW-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_LD,   R_POS, SRC_ZERO, R_T, 1'b0);
      6'd1:  u = mk(OP_LD,   R_VEL, SRC_ZERO, R_T, 1'b0);
      6'd2:  u = mk(OP_LD,   R_CPP, SRC_TEN,  R_T, 1'b0);
      6'd3:  u = mk(OP_LD,   R_CPV, SRC_ZERO, R_T, 1'b0);
      6'd4:  u = mk(OP_LD,   R_CVV, SRC_TEN,  R_T, 1'b0);
      6'd5:  u = mk(OP_LD,   R_DT,  SRC_DT,   R_T, 1'b0);
      6'd6:  u = mk(OP_LD,   R_SG,  SRC_SG,   R_T, 1'b0);
      6'd7:  u = mk(OP_MUL,  R_S2,  R_SG,  R_SG,  1'b0);
      6'd8:  u = mk(OP_MUL,  R_D2,  R_DT,  R_DT,  1'b0);
      6'd9:  u = mk(OP_MUL,  R_D3,  R_D2,  R_DT,  1'b0);
      6'd10: u = mk(OP_MUL,  R_D4,  R_D2,  R_D2,  1'b0);
      6'd11: u = mk(OP_MUL,  R_T,   R_S2,  R_D4,  1'b0);
      6'd12: u = mk(OP_SHR2, R_NPP, R_T,   R_T,   1'b0);
      6'd13: u = mk(OP_MUL,  R_T,   R_S2,  R_D3,  1'b0);
      6'd14: u = mk(OP_SHR1, R_NPV, R_T,   R_T,   1'b0);
      6'd15: u = mk(OP_MUL,  R_NVV, R_S2,  R_D2,  1'b1);
      6'd16: u = mk(OP_LD,   R_DT,  SRC_DT,  R_T, 1'b0);
      6'd17: u = mk(OP_LD,   R_R,   SRC_R,   R_T, 1'b0);
      6'd18: u = mk(OP_LD,   R_Z,   SRC_Z,   R_T, 1'b0);
      6'd19: u = mk(OP_LD,   R_ONE, SRC_ONE, R_T, 1'b0);
      6'd20: u = mk(OP_MUL,  R_T,   R_DT,  R_VEL, 1'b0);
      6'd21: u = mk(OP_ADD,  R_POS, R_POS, R_T,   1'b0);
      6'd22: u = mk(OP_MUL,  R_T,   R_DT,  R_CPV, 1'b0);
      6'd23: u = mk(OP_ADD,  R_A,   R_CPP, R_T,   1'b0);
      6'd24: u = mk(OP_MUL,  R_T,   R_DT,  R_CVV, 1'b0);
      6'd25: u = mk(OP_ADD,  R_B,   R_CPV, R_T,   1'b0);
      6'd26: u = mk(OP_MUL,  R_T,   R_DT,  R_B,   1'b0);
      6'd27: u = mk(OP_ADD,  R_T,   R_A,   R_T,   1'b0);
      6'd28: u = mk(OP_ADD,  R_CPP, R_T,   R_NPP, 1'b0);
      6'd29: u = mk(OP_ADD,  R_CPV, R_B,   R_NPV, 1'b0);
      6'd30: u = mk(OP_ADD,  R_CVV, R_CVV, R_NVV, 1'b0);
      6'd31: u = mk(OP_SUB,  R_Y,   R_Z,   R_POS, 1'b0);
      6'd32: u = mk(OP_ADD,  R_S,   R_CPP, R_R,   1'b0);
      6'd33: u = mk(OP_DIV,  R_K0,  R_CPP, R_S,   1'b0);
      6'd34: u = mk(OP_DIV,  R_K1,  R_CPV, R_S,   1'b0);
      6'd35: u = mk(OP_MUL,  R_T,   R_K0,  R_Y,   1'b0);
      6'd36: u = mk(OP_ADD,  R_POS, R_POS, R_T,   1'b0);
      6'd37: u = mk(OP_MUL,  R_T,   R_K1,  R_Y,   1'b0);
      6'd38: u = mk(OP_ADD,  R_VEL, R_VEL, R_T,   1'b0);
      6'd39: u = mk(OP_SUB,  R_G,   R_ONE, R_K0,  1'b0);
      6'd40: u = mk(OP_MUL,  R_M00, R_G,   R_CPP, 1'b0);
      6'd41: u = mk(OP_MUL,  R_M01, R_G,   R_CPV, 1'b0);
      6'd42: u = mk(OP_MUL,  R_T,   R_K1,  R_CPP, 1'b0);
      6'd43: u = mk(OP_SUB,  R_M10, R_CPV, R_T,   1'b0);
      6'd44: u = mk(OP_MUL,  R_T,   R_K1,  R_CPV, 1'b0);
      6'd45: u = mk(OP_SUB,  R_M11, R_CVV, R_T,   1'b0);
      6'd46: u = mk(OP_MUL,  R_KR0, R_K0,  R_R,   1'b0);
      6'd47: u = mk(OP_MUL,  R_KR1, R_K1,  R_R,   1'b0);
      6'd48: u = mk(OP_MUL,  R_T,   R_G,   R_M00, 1'b0);
      6'd49: u = mk(OP_MUL,  R_U,   R_K0,  R_KR0, 1'b0);
      6'd50: u = mk(OP_ADD,  R_CPP, R_T,   R_U,   1'b0);
      6'd51: u = mk(OP_MUL,  R_T,   R_K1,  R_M00, 1'b0);
      6'd52: u = mk(OP_SUB,  R_T,   R_M01, R_T,   1'b0);
      6'd53: u = mk(OP_MUL,  R_U,   R_K1,  R_KR0, 1'b0);
      6'd54: u = mk(OP_ADD,  R_CPV, R_T,   R_U,   1'b0);
      6'd55: u = mk(OP_MUL,  R_T,   R_K1,  R_M10, 1'b0);
      6'd56: u = mk(OP_SUB,  R_T,   R_M11, R_T,   1'b0);
      6'd57: u = mk(OP_MUL,  R_U,   R_K1,  R_KR1, 1'b0);
      6'd58: u = mk(OP_ADD,  R_CVV, R_T,   R_U,   1'b0);
      6'd59: u = mk(OP_OUTP, R_T,   R_POS, R_T,   1'b0);
      6'd60: u = mk(OP_OUTV, R_T,   R_VEL, R_T,   1'b0);
      6'd61: u = mk(OP_OUTC, R_T,   R_CPP, R_T,   1'b1);
      default: u = mk(OP_OUTC, R_T, R_CPP, R_T, 1'b1);
    endcase
    return u;
  endfunction

endpackage

@@ hdl/kalman_constant_velocity_filter.sv @@
// Each accepted measurement runs the step micro-program (18 multiplies, two divides and
// 26 ALU steps) before m_axis_tvalid is raised.
// One item at a time: a new item is accepted only after the previous result has been emitted.
// The next measurement is taken while a finished result still waits on the output.
// After reset the state is loaded and process noise computed (tready low);
// a write to time_step or accel_sigma reruns the noise computation before the next transfer.
module kalman_constant_velocity_filter #(
  parameter int FRAC_BITS   = 24,
  parameter int STATE_WIDTH = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] measurement
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [31:0] position_estimate, [63:32] velocity_estimate,
                                      // [95:64] position_variance
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  kcv_pkg::cmd_t cmd;
  kcv_pkg::sts_t sts;

  kcv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kcv_datapath #(.W(STATE_WIDTH), .F(FRAC_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

@@ hdl/kcv_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module kcv_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ hdl/kcv_mul.sv @@
// Fixed-point multiplier: four half-width partial products, rounding and saturation.
module kcv_mul #(
  parameter int W = 48,
  parameter int F = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         done_o,
  output logic [W-1:0] res_o
);

  localparam int H = (W + 1) / 2;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic           busy_q, done_q;
  logic [2:0]     cnt_q;
  logic [W-1:0]   am_q, bm_q, res_q;
  logic           neg_q;
  logic [2*W-1:0] acc_q;
  logic [2*H-1:0] pp_q;
  logic [1:0]     sh_q;
  logic [H-1:0]   a_part, b_part;
  logic [2*W-1:0] q;

  always_comb begin
    a_part = cnt_q[1] ? H'(am_q >> H) : H'(am_q);
    b_part = cnt_q[0] ? H'(bm_q >> H) : H'(bm_q);
    q      = (acc_q >> F) + (2*W)'(acc_q[F-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      am_q  <= a_i[W-1] ? (~a_i + W'(1)) : a_i;
      bm_q  <= b_i[W-1] ? (~b_i + W'(1)) : b_i;
      neg_q <= a_i[W-1] ^ b_i[W-1];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < 3'd4) begin
        pp_q <= (2*H)'(a_part) * (2*H)'(b_part);
        sh_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
      end
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
        acc_q <= acc_q + ((2*W)'(pp_q) << (H * int'(sh_q)));
      end
      if (cnt_q == 3'd5) begin
        if (neg_q) begin
          res_q <= (q > (2*W)'(SMIN)) ? SMIN : (~W'(q) + W'(1));
        end else begin
          res_q <= (q > (2*W)'(SMAX)) ? SMAX : W'(q);
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ hdl/kcv_div.sv @@
// Fixed-point divider: restoring, one quotient bit per cycle, round and saturate.
module kcv_div #(
  parameter int W = 48,
  parameter int F = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] n_i,
  input  logic [W-1:0] d_i,
  output logic         done_o,
  output logic [W-1:0] res_o
);

  localparam int DW = W + F;
  localparam int CW = $clog2(DW + 1);
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  md_q, res_q;
  logic          neg_q;
  logic [DW-1:0] dvd_q, quo_q;
  logic [W:0]    rem_q, remx;
  logic          qbit, rbit;
  logic [DW:0]   q1;

  always_comb begin
    remx = {rem_q[W-1:0], dvd_q[DW-1]};
    qbit = remx >= {1'b0, md_q};
    rbit = rem_q >= ({1'b0, md_q} - rem_q);
    q1   = (DW+1)'(quo_q) + (DW+1)'(rbit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DW)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      md_q  <= d_i[W-1] ? (~d_i + W'(1)) : d_i;
      dvd_q <= {(n_i[W-1] ? (~n_i + W'(1)) : n_i), {F{1'b0}}};
      neg_q <= n_i[W-1] ^ d_i[W-1];
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < CW'(DW)) begin
        rem_q <= qbit ? (remx - {1'b0, md_q}) : remx;
        dvd_q <= dvd_q << 1;
        quo_q <= {quo_q[DW-2:0], qbit};
      end else if (md_q == '0) begin
        res_q <= '0;
      end else if (neg_q) begin
        res_q <= (q1 > (DW+1)'(SMIN)) ? SMIN : (~W'(q1) + W'(1));
      end else begin
        res_q <= (q1 > (DW+1)'(SMAX)) ? SMAX : W'(q1);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ hdl/kcv_datapath.sv @@
// Datapath: config registers, operand RAM, saturating ALU, multiplier, divider, output stage.
module kcv_datapath #(
  parameter int W = 48,
  parameter int F = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kcv_pkg::cmd_t cmd_i,
  output kcv_pkg::sts_t sts_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic [31:0]   in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [95:0]   out_data_o
);

  localparam int LW = 32 + F;
  localparam int XW = ((LW > W) ? LW : W) + 1;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE  = W'(1) << F;
  localparam logic [W-1:0] TEN  = W'(10) << F;

  logic [15:0]  dt_q;
  logic [23:0]  sg_q;
  logic [31:0]  r_q, z_q;
  logic [31:0]  pos_s_q, vel_s_q, cov_s_q;
  logic [95:0]  out_q;
  logic         valid_q;
  logic [W-1:0] ra, rb, alu, wdata, mul_res, div_res;
  logic         mul_done, div_done, we;
  kcv_pkg::op_e op;

  function automatic logic [W-1:0] add_sat(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic sub);
    logic [W:0] s;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (s[W] != s[W-1]) return s[W] ? SMIN : SMAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] shr_round(input logic [W-1:0] a, input logic two);
    logic [W-1:0] m, r;
    m = a[W-1] ? (~a + W'(1)) : a;
    r = two ? ((m >> 2) + W'(m[1])) : ((m >> 1) + W'(m[0]));
    return a[W-1] ? (~r + W'(1)) : r;
  endfunction

  function automatic logic [W-1:0] from_u(input logic [31:0] v);
    logic [LW-1:0] x;
    x = LW'(v) << (F - 16);
    if (XW'(x) > XW'(SMAX)) return SMAX;
    return W'(x);
  endfunction

  function automatic logic [W-1:0] from_z(input logic [31:0] v);
    logic signed [LW-1:0] x;
    logic signed [XW-1:0] xe, smax_x, smin_x;
    x      = LW'($signed(v)) <<< (F - 16);
    xe     = XW'(x);
    smax_x = XW'(SMAX);
    smin_x = XW'($signed(SMIN));
    if (xe > smax_x) return SMAX;
    if (xe < smin_x) return SMIN;
    return W'(xe);
  endfunction

  function automatic logic [W-1:0] to_q16(input logic [W-1:0] m);
    logic [W:0] e;
    e = {m, 1'b0} >> (F - 16);
    return W'(e >> 1) + W'(e[0]);
  endfunction

  function automatic logic [31:0] out_s(input logic [W-1:0] v);
    logic [W-1:0] r;
    r = to_q16(v[W-1] ? (~v + W'(1)) : v);
    if (v[W-1]) begin
      if (r > W'(33'h080000000)) return 32'h80000000;
      return ~r[31:0] + 32'd1;
    end
    if (r > W'(33'h07FFFFFFF)) return 32'h7FFFFFFF;
    return r[31:0];
  endfunction

  function automatic logic [31:0] out_u(input logic [W-1:0] v);
    logic [W-1:0] r;
    r = to_q16(v);
    if (v[W-1]) return 32'd0;
    if (r > W'(33'h0FFFFFFFF)) return 32'hFFFFFFFF;
    return r[31:0];
  endfunction

  assign op = cmd_i.uop.op;

  always_comb begin
    case (op)
      kcv_pkg::OP_LD: begin
        case (cmd_i.uop.sa)
          kcv_pkg::SRC_ONE: alu = ONE;
          kcv_pkg::SRC_TEN: alu = TEN;
          kcv_pkg::SRC_DT:  alu = from_u(32'(dt_q));
          kcv_pkg::SRC_SG:  alu = from_u(32'(sg_q));
          kcv_pkg::SRC_R:   alu = from_u(r_q);
          kcv_pkg::SRC_Z:   alu = from_z(z_q);
          default:          alu = '0;
        endcase
      end
      kcv_pkg::OP_ADD:  alu = add_sat(ra, rb, 1'b0);
      kcv_pkg::OP_SUB:  alu = add_sat(ra, rb, 1'b1);
      kcv_pkg::OP_SHR1: alu = shr_round(ra, 1'b0);
      kcv_pkg::OP_SHR2: alu = shr_round(ra, 1'b1);
      default:          alu = ra;
    endcase
    we = cmd_i.wb || (cmd_i.exec && (op == kcv_pkg::OP_LD || op == kcv_pkg::OP_ADD ||
         op == kcv_pkg::OP_SUB || op == kcv_pkg::OP_SHR1 || op == kcv_pkg::OP_SHR2));
    if (cmd_i.wb) begin
      wdata = (op == kcv_pkg::OP_MUL) ? mul_res : div_res;
    end else begin
      wdata = alu;
    end
  end

  kcv_ram #(.WIDTH(W), .DEPTH(kcv_pkg::RF_DEPTH)) u_rf (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (cmd_i.uop.dst),
    .wdata_i   (wdata),
    .raddr_a_i (cmd_i.uop.sa),
    .raddr_b_i (cmd_i.uop.sb),
    .rdata_a_o (ra),
    .rdata_b_o (rb)
  );

  kcv_mul #(.W(W), .F(F)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.exec && op == kcv_pkg::OP_MUL),
    .a_i     (ra),
    .b_i     (rb),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  kcv_div #(.W(W), .F(F)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.exec && op == kcv_pkg::OP_DIV),
    .n_i     (ra),
    .d_i     (rb),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q    <= kcv_pkg::DT_RESET;
      sg_q    <= kcv_pkg::SG_RESET;
      r_q     <= kcv_pkg::R_RESET;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kcv_pkg::CFG_DT: dt_q <= cfg_data_i[15:0];
          kcv_pkg::CFG_SG: sg_q <= cfg_data_i[23:0];
          kcv_pkg::CFG_R:  r_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.emit) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      z_q <= in_data_i;
    end
    if (cmd_i.exec && op == kcv_pkg::OP_OUTP) begin
      pos_s_q <= out_s(ra);
    end
    if (cmd_i.exec && op == kcv_pkg::OP_OUTV) begin
      vel_s_q <= out_s(ra);
    end
    if (cmd_i.exec && op == kcv_pkg::OP_OUTC) begin
      cov_s_q <= out_u(ra);
    end
    if (cmd_i.emit) begin
      out_q <= {cov_s_q, vel_s_q, pos_s_q};
    end
  end

  assign sts_o.mul_done  = mul_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !valid_q || out_ready_i;
  assign sts_o.cfg_noise = cfg_we_i && (cfg_idx_i == kcv_pkg::CFG_DT ||
                                        cfg_idx_i == kcv_pkg::CFG_SG);
  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/kcv_ctrl.sv @@
// Controller: micro-program sequencer driving the datapath.
module kcv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kcv_pkg::sts_t sts_i,
  output kcv_pkg::cmd_t cmd_o
);

  kcv_pkg::state_e            state_q, state_d;
  logic [kcv_pkg::PCW-1:0]    pc_q, pc_d;
  logic                       is_step_q, is_step_d;
  logic                       noise_req_q, noise_req_d;
  kcv_pkg::uop_t              uop;
  logic                       unit_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kcv_pkg::S_FETCH;
      pc_q        <= kcv_pkg::PC_INIT;
      is_step_q   <= 1'b0;
      noise_req_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      is_step_q   <= is_step_d;
      noise_req_q <= noise_req_d;
    end
  end

  always_comb begin
    uop         = kcv_pkg::ucode(pc_q);
    unit_done   = (uop.op == kcv_pkg::OP_MUL) ? sts_i.mul_done : sts_i.div_done;
    state_d     = state_q;
    pc_d        = pc_q;
    is_step_d   = is_step_q;
    noise_req_d = noise_req_q || sts_i.cfg_noise;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.uop   = uop;
    case (state_q)
      kcv_pkg::S_IDLE: begin
        if (noise_req_q) begin
          noise_req_d = sts_i.cfg_noise;
          pc_d        = kcv_pkg::PC_NOISE;
          is_step_d   = 1'b0;
          state_d     = kcv_pkg::S_FETCH;
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.accept = 1'b1;
            pc_d         = kcv_pkg::PC_STEP;
            is_step_d    = 1'b1;
            state_d      = kcv_pkg::S_FETCH;
          end
        end
      end
      kcv_pkg::S_FETCH: state_d = kcv_pkg::S_EXEC;
      kcv_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (uop.op == kcv_pkg::OP_MUL || uop.op == kcv_pkg::OP_DIV) begin
          state_d = kcv_pkg::S_WAIT;
        end else if (uop.last) begin
          state_d = is_step_q ? kcv_pkg::S_EMIT : kcv_pkg::S_IDLE;
        end else begin
          pc_d    = pc_q + kcv_pkg::PCW'(1);
          state_d = kcv_pkg::S_FETCH;
        end
      end
      kcv_pkg::S_WAIT: begin
        if (unit_done) begin
          cmd_o.wb = 1'b1;
          if (uop.last) begin
            state_d = is_step_q ? kcv_pkg::S_EMIT : kcv_pkg::S_IDLE;
          end else begin
            pc_d    = pc_q + kcv_pkg::PCW'(1);
            state_d = kcv_pkg::S_FETCH;
          end
        end
      end
      kcv_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = kcv_pkg::S_IDLE;
        end
      end
      default: state_d = kcv_pkg::S_IDLE;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == kcv_pkg::S_FETCH && pc_q == kcv_pkg::PC_STEP))
    else $error("accepted item did not start the step program");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wb |-> (state_q == kcv_pkg::S_WAIT && unit_done))
    else $error("unit write-back outside wait");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (sts_i.out_free && is_step_q))
    else $error("result emitted into a busy output register");

endmodule

@@ bench/kalman_constant_velocity_filter_tb.sv @@
// Self-checking bench for the constant-velocity Kalman filter with a bit-exact predictor.
`timescale 1ns / 1ps

module kalman_constant_velocity_filter_tb;

  localparam longint SMAX = (longint'(1) <<< 47) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint ONE  = longint'(1) <<< 24;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] var_pp;
  } estimate_t;

  class kalman_scoreboard;
    longint dt_q, sg_q, r_q;
    longint pos_est, vel_est, cov_pp, cov_pv, cov_vv, npp, npv, nvv;
    estimate_t pending[$];
    int errors;

    function longint clamp_sm(bit neg, logic [127:0] m);
      if (neg) begin
        if (m > (128'd1 << 47)) return SMIN;
        return -longint'(m[63:0]);
      end
      if (m > 128'(SMAX)) return SMAX;
      return longint'(m[63:0]);
    endfunction

    function logic [127:0] magn(longint v);
      return 128'(v < 0 ? -v : v);
    endfunction

    function logic [127:0] rshr(logic [127:0] m, int s);
      return (m >> s) + ((m >> (s - 1)) & 128'd1);
    endfunction

    function longint fmul(longint a, longint b);
      logic [127:0] p;
      p = magn(a) * magn(b);
      return clamp_sm((a < 0) != (b < 0), (p >> 24) + p[23]);
    endfunction

    function longint fdiv(longint n, longint d);
      logic [127:0] num, md, q, rm;
      md = magn(d);
      if (md == 0) return 0;
      num = magn(n) << 24;
      q = num / md;
      rm = num % md;
      if (rm >= md - rm) q = q + 1;
      return clamp_sm((n < 0) != (d < 0), q);
    endfunction

    function longint sadd(longint a, longint b);
      longint s;
      s = a + b;
      return s > SMAX ? SMAX : (s < SMIN ? SMIN : s);
    endfunction

    function longint ssub(longint a, longint b);
      longint s;
      s = a - b;
      return s > SMAX ? SMAX : (s < SMIN ? SMIN : s);
    endfunction

    function longint shr_round(longint v, int s);
      return clamp_sm(v < 0, rshr(magn(v), s));
    endfunction

    function logic [31:0] out_signed(longint v);
      logic [127:0] m;
      m = rshr(magn(v), 8);
      if (v < 0) begin
        if (m > 128'h8000_0000) m = 128'h8000_0000;
        return 32'(-m[63:0]);
      end
      if (m > 128'h7FFF_FFFF) m = 128'h7FFF_FFFF;
      return m[31:0];
    endfunction

    function logic [31:0] out_unsigned(longint v);
      logic [127:0] m;
      if (v < 0) return 32'd0;
      m = rshr(magn(v), 8);
      return m > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : m[31:0];
    endfunction

    function void derive_noise();
      longint s2, d2, d3, d4;
      s2 = fmul(sg_q, sg_q);
      d2 = fmul(dt_q, dt_q);
      d3 = fmul(d2, dt_q);
      d4 = fmul(d2, d2);
      npp = shr_round(fmul(s2, d4), 2);
      npv = shr_round(fmul(s2, d3), 1);
      nvv = fmul(s2, d2);
    endfunction

    function new();
      dt_q = longint'(kcv_pkg::DT_RESET) <<< 8;
      sg_q = longint'(kcv_pkg::SG_RESET) <<< 8;
      r_q  = longint'(kcv_pkg::R_RESET) <<< 8;
      pos_est = 0; vel_est = 0; cov_pp = 10 * ONE; cov_pv = 0; cov_vv = 10 * ONE;
      errors = 0;
      derive_noise();
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        kcv_pkg::CFG_DT: begin dt_q = longint'(val[15:0]) <<< 8; derive_noise(); end
        kcv_pkg::CFG_SG: begin sg_q = longint'(val[23:0]) <<< 8; derive_noise(); end
        kcv_pkg::CFG_R:  r_q = longint'(val) <<< 8;
        default: ;
      endcase
    endfunction

    function void note_measurement(logic [31:0] zr);
      longint z, a, b, y, s, k0, k1, g, m00, m01, m10, m11, kr0, kr1;
      estimate_t e;
      z = longint'($signed(zr)) <<< 8;
      pos_est = sadd(pos_est, fmul(dt_q, vel_est));
      a = sadd(cov_pp, fmul(dt_q, cov_pv));
      b = sadd(cov_pv, fmul(dt_q, cov_vv));
      cov_pp = sadd(sadd(a, fmul(dt_q, b)), npp);
      cov_pv = sadd(b, npv);
      cov_vv = sadd(cov_vv, nvv);
      y = ssub(z, pos_est);
      s = sadd(cov_pp, r_q);
      k0 = fdiv(cov_pp, s);
      k1 = fdiv(cov_pv, s);
      pos_est = sadd(pos_est, fmul(k0, y));
      vel_est = sadd(vel_est, fmul(k1, y));
      g = ssub(ONE, k0);
      m00 = fmul(g, cov_pp);
      m01 = fmul(g, cov_pv);
      m10 = ssub(cov_pv, fmul(k1, cov_pp));
      m11 = ssub(cov_vv, fmul(k1, cov_pv));
      kr0 = fmul(k0, r_q);
      kr1 = fmul(k1, r_q);
      cov_pp = sadd(fmul(g, m00), fmul(k0, kr0));
      cov_pv = sadd(ssub(m01, fmul(k1, m00)), fmul(k1, kr0));
      cov_vv = sadd(ssub(m11, fmul(k1, m10)), fmul(k1, kr1));
      e.pos = out_signed(pos_est);
      e.vel = out_signed(vel_est);
      e.var_pp = out_unsigned(cov_pp);
      pending.push_back(e);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_estimate(logic [95:0] d);
      estimate_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", d[31:0], 32'd0);
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.pos) report_mismatch("position_estimate", d[31:0], e.pos);
      if (d[63:32] !== e.vel) report_mismatch("velocity_estimate", d[63:32], e.vel);
      if (d[95:64] !== e.var_pp) report_mismatch("position_variance", d[95:64], e.var_pp);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  kalman_scoreboard sb = new();
  bit quiet = 1'b0;
  int out_hold = 0;
  longint traj_pos = 0, traj_vel = 0;

  always #4 clk_i = ~clk_i;

  kalman_constant_velocity_filter i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_estimate(m_axis_tdata);
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      out_hold <= $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  task send_measurement(logic [31:0] z);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= z;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_measurement(z);
  endtask

  task write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function logic [31:0] pick_measurement();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      if ($urandom_range(0, 63) == 0) begin
        traj_pos = longint'($signed($urandom_range(0, 32'h00FF_FFFF))) - 64'h0080_0000;
        traj_vel = longint'($urandom_range(0, 32'h0004_0000)) - 64'h0002_0000;
      end
      traj_pos = traj_pos + traj_vel + longint'($urandom_range(0, 32'h8000)) - 64'h4000;
      if (traj_pos > 64'sh7FFF_FFFF || traj_pos < -64'sh8000_0000) traj_pos = 0;
      return traj_pos[31:0];
    end
    if (sel < 85) return $urandom();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return 32'h1;
    endcase
  endfunction

  logic [31:0] directed[] = '{32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                              32'hFFFF_FFFF, 32'h1, 32'h0, 32'hFFFF_0000, 32'h5555_5555,
                              32'hAAAA_AAAA, 32'h0};
  logic [31:0] phase_dt[] = '{32'd65535, 32'd1, 32'd0, 32'hFFFF_0100, 32'd32768, 32'd6554,
                              32'd0, 32'd3000};
  logic [31:0] phase_sg[] = '{32'hFF_FFFF, 32'd0, 32'd0, 32'hFF00_1000, 32'h1_0000,
                              32'd13107, 32'd0, 32'd500};
  logic [31:0] phase_r[]  = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd65536, 32'h2_0000,
                              32'd1, 32'd0, 32'd65536};

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) send_measurement(directed[i]);
    for (int p = 0; p < phase_dt.size(); p++) begin
      drain();
      if (p == phase_dt.size() - 1) quiet = 1'b1;
      write_reg(kcv_pkg::CFG_DT, phase_dt[p]);
      write_reg(kcv_pkg::CFG_SG, phase_sg[p]);
      write_reg(kcv_pkg::CFG_R, phase_r[p]);
      if (p == 3) write_reg(CFG_UNUSED, $urandom());
      if (p == 6) begin
        // zero dt, sigma and r: covariance collapses and S reaches zero
        repeat (6) send_measurement(32'h0001_0000);
      end
      if (p == 4) write_reg(kcv_pkg::CFG_DT, $urandom());
      repeat (250) send_measurement(pick_measurement());
    end
    drain();
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
